### rtl/core/rpb_pkg.sv
// ----------------------------------------------------------------------------
// Record packing buffer ring: shared package
// Types, field widths, request codes and helper functions for the buffer
// ring core, its controller and its checker.
// ----------------------------------------------------------------------------
package rpb_pkg;

  // Default geometry of the ring.
  localparam int BUF_BYTES_DEF = 512;
  localparam int NUM_BUFS_DEF  = 4;

  // Fixed field widths of the transaction payloads.
  localparam int REC_LEN_W     = 12;
  localparam int HEAD_LEN_W    = 8;
  localparam int BYTE_W        = 8;
  localparam int OFFSET_W      = 9;
  localparam int LEN_FIELD_W   = 10;
  localparam int COUNT_FIELD_W = 3;
  localparam int CTR_W         = 16;

  // Width for record plus header length sums and the buffer size compare.
  localparam int SUM_W         = REC_LEN_W + 2;

  // Request codes; the two unused codes do nothing.
  typedef enum logic [2:0] {
    REQ_PUT_START  = 3'd0,
    REQ_PUT_DATA   = 3'd1,
    REQ_QUEUE      = 3'd2,
    REQ_DRAIN_READ = 3'd3,
    REQ_WRITE_DONE = 3'd4,
    REQ_CLEAR      = 3'd5
  } req_t;

  // Answer to a put start.
  typedef enum logic [1:0] {
    PS_APPENDED = 2'd0,
    PS_FRESH    = 2'd1,
    PS_REFUSED  = 2'd2,
    PS_NONE     = 2'd3
  } put_status_t;

  // Input transaction payload.
  typedef struct packed {
    req_t                  req_type;
    logic [REC_LEN_W-1:0]  rec_len;
    logic [HEAD_LEN_W-1:0] head_len;
    logic [BYTE_W-1:0]     data_byte;
    logic                  is_header;
    logic [OFFSET_W-1:0]   read_offset;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    put_status_t              put_status;
    logic                     queue_accepted;
    logic                     drain_valid;
    logic [LEN_FIELD_W-1:0]   drain_len;
    logic [BYTE_W-1:0]        read_data;
    logic [COUNT_FIELD_W-1:0] queued_count;
    logic [LEN_FIELD_W-1:0]   open_bytes;
    logic [CTR_W-1:0]         oversize_refusals;
    logic [CTR_W-1:0]         full_refusals;
  } out_item_t;

  // Per-transaction answer registered by the controller.
  typedef struct packed {
    put_status_t put_status;
    logic        queue_accepted;
    logic        read_hit;
  } rsp_t;

  // Ring status as seen after the last transaction.
  typedef struct packed {
    logic                     drain_valid;
    logic [LEN_FIELD_W-1:0]   drain_len;
    logic [COUNT_FIELD_W-1:0] queued_count;
    logic [LEN_FIELD_W-1:0]   open_bytes;
    logic [CTR_W-1:0]         oversize_refusals;
    logic [CTR_W-1:0]         full_refusals;
  } view_t;

  // Saturating increment of a refusal counter.
  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

### rtl/core/record_packing_buffer_ring_core.sv
// ----------------------------------------------------------------------------
// Record packing buffer ring core
// Packs header and record bytes into a ring of fixed-size buffers and drains
// the oldest queued buffer, with saturating refusal counters.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ----------------------
//  input     start, busy                in_item  (in_item_t)
//  result    out_strobe (one cycle)     out_item (out_item_t)
//
// One transaction is taken every cycle; busy stays low. Its result appears
// on the cycle after acceptance, set by the registered read of the byte store.
// Every transaction makes at most one access to the single-port byte store,
// so writes and drain reads never contend.
// Synchronous reset clears the pointers, lengths, pending put and counters;
// the byte store is not cleared, and reads stay below the stored lengths.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module record_packing_buffer_ring_core
  import rpb_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF,
  parameter int NUM_BUFS  = NUM_BUFS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int DEPTH  = NUM_BUFS * BUF_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              accept;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;
  rsp_t              rsp;
  view_t             view;
  logic              strobe_r;

  // The core never holds off a transaction, so busy is tied low.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  rpb_ring_ctrl #(
    .BUF_BYTES (BUF_BYTES),
    .NUM_BUFS  (NUM_BUFS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .rsp       (rsp),
    .view      (view)
  );

  rpb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_byte_store (
    .clk   (clk),
    .we    (accept && ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Result strobe is accept, registered: it is high in the cycle after each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
    end
  end

  assign out_strobe = strobe_r;

  // Assemble the result from the registered answer, store data and status.
  assign out_item.put_status        = rsp.put_status;
  assign out_item.queue_accepted    = rsp.queue_accepted;
  assign out_item.drain_valid       = view.drain_valid;
  assign out_item.drain_len         = view.drain_len;
  assign out_item.read_data         = rsp.read_hit ? ram_rdata : '0;
  assign out_item.queued_count      = view.queued_count;
  assign out_item.open_bytes        = view.open_bytes;
  assign out_item.oversize_refusals = view.oversize_refusals;
  assign out_item.full_refusals     = view.full_refusals;

endmodule

### rtl/core/rpb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle at one address; the read data is registered.
// ----------------------------------------------------------------------------
module rpb_ram
  import rpb_pkg::*;
#(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = NUM_BUFS_DEF * BUF_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/rpb_ring_ctrl.sv
// ----------------------------------------------------------------------------
// Buffer ring controller
// Keeps the ring pointers, buffer lengths, pending put state and refusal
// counters, and drives the byte store address for each transaction.
// ----------------------------------------------------------------------------
module rpb_ring_ctrl
  import rpb_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF,
  parameter int NUM_BUFS  = NUM_BUFS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    accept,
  input  in_item_t                                in_item,
  output logic                                    ram_we,
  output logic [$clog2(NUM_BUFS*BUF_BYTES)-1:0]   ram_addr,
  output logic [BYTE_W-1:0]                       ram_wdata,
  output rsp_t                                    rsp,
  output view_t                                   view
);

  localparam int LEN_W  = $clog2(BUF_BYTES + 1);
  localparam int IDX_W  = $clog2(NUM_BUFS);
  localparam int CNT_W  = $clog2(NUM_BUFS + 1);
  localparam int ADDR_W = $clog2(NUM_BUFS * BUF_BYTES);

  // Next buffer in ring order.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(NUM_BUFS - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [IDX_W-1:0]      fill_idx_r,  fill_idx_nxt;
  logic [IDX_W-1:0]      drain_idx_r, drain_idx_nxt;
  logic [CNT_W-1:0]      count_r,     count_nxt;
  logic [LEN_W-1:0]      open_len_r,  open_len_nxt;
  logic [LEN_W-1:0]      drain_len_r, drain_len_nxt;
  logic                  active_r,    active_nxt;
  logic [HEAD_LEN_W-1:0] head_rem_r,  head_rem_nxt;
  logic [REC_LEN_W-1:0]  rec_rem_r,   rec_rem_nxt;
  logic [CTR_W-1:0]      ovs_ctr_r,   ovs_ctr_nxt;
  logic [CTR_W-1:0]      full_ctr_r,  full_ctr_nxt;
  rsp_t                  rsp_r,       rsp_nxt;

  // Lengths of closed buffers, written at close and read at the next drain.
  logic [LEN_W-1:0]      len_r [NUM_BUFS];
  logic                  len_we;

  logic                  full;
  logic [SUM_W-1:0]      need;
  logic [SUM_W-1:0]      room;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  rd_hit;
  logic                  take;

  assign full    = (count_r == CNT_W'(NUM_BUFS));
  assign need    = SUM_W'(in_item.rec_len) + SUM_W'(in_item.head_len);
  assign room    = SUM_W'(BUF_BYTES) - SUM_W'(open_len_r);
  assign wr_addr = ADDR_W'(fill_idx_r) * ADDR_W'(BUF_BYTES) + ADDR_W'(open_len_r);
  assign rd_addr = ADDR_W'(drain_idx_r) * ADDR_W'(BUF_BYTES)
                 + ADDR_W'(in_item.read_offset);
  assign rd_hit  = (count_r != '0)
                 && (SUM_W'(in_item.read_offset) < SUM_W'(drain_len_r));

  // A data byte is taken when room is left and it matches the pending put.
  assign take = active_r && !full && (open_len_r < LEN_W'(BUF_BYTES))
              && (in_item.is_header ? (head_rem_r != '0)
                                    : ((head_rem_r == '0) && (rec_rem_r != '0)));

  // Next-state logic for one transaction.
  always_comb begin
    fill_idx_nxt  = fill_idx_r;
    drain_idx_nxt = drain_idx_r;
    count_nxt     = count_r;
    open_len_nxt  = open_len_r;
    drain_len_nxt = drain_len_r;
    active_nxt    = active_r;
    head_rem_nxt  = head_rem_r;
    rec_rem_nxt   = rec_rem_r;
    ovs_ctr_nxt   = ovs_ctr_r;
    full_ctr_nxt  = full_ctr_r;
    rsp_nxt       = '{put_status: PS_NONE, queue_accepted: 1'b0, read_hit: 1'b0};
    len_we        = 1'b0;
    ram_we        = 1'b0;

    case (in_item.req_type)
      REQ_PUT_START: begin
        if (in_item.rec_len == '0) begin
          rsp_nxt.put_status = PS_APPENDED;
        end else if (need > SUM_W'(BUF_BYTES)) begin
          ovs_ctr_nxt        = sat_inc(ovs_ctr_r);
          rsp_nxt.put_status = PS_REFUSED;
        end else begin
          active_nxt   = 1'b0;
          head_rem_nxt = '0;
          rec_rem_nxt  = '0;
          if (full) begin
            full_ctr_nxt       = sat_inc(full_ctr_r);
            rsp_nxt.put_status = PS_REFUSED;
          end else if ((open_len_r != '0) && (SUM_W'(in_item.rec_len) > room)) begin
            // The record does not fit: close and queue the open buffer first.
            len_we       = 1'b1;
            fill_idx_nxt = idx_inc(fill_idx_r);
            count_nxt    = count_r + 1'b1;
            open_len_nxt = '0;
            if (count_r == '0) begin
              drain_len_nxt = open_len_r;
            end
            if (count_r == CNT_W'(NUM_BUFS - 1)) begin
              full_ctr_nxt       = sat_inc(full_ctr_r);
              rsp_nxt.put_status = PS_REFUSED;
            end else begin
              active_nxt         = 1'b1;
              rec_rem_nxt        = in_item.rec_len;
              head_rem_nxt       = in_item.head_len;
              rsp_nxt.put_status = PS_FRESH;
            end
          end else begin
            active_nxt  = 1'b1;
            rec_rem_nxt = in_item.rec_len;
            if (open_len_r == '0) begin
              head_rem_nxt       = in_item.head_len;
              rsp_nxt.put_status = PS_FRESH;
            end else begin
              rsp_nxt.put_status = PS_APPENDED;
            end
          end
        end
      end

      REQ_PUT_DATA: begin
        if (take) begin
          ram_we       = 1'b1;
          open_len_nxt = open_len_r + 1'b1;
          if (in_item.is_header) begin
            head_rem_nxt = head_rem_r - 1'b1;
            if ((head_rem_r == HEAD_LEN_W'(1)) && (rec_rem_r == '0)) begin
              active_nxt = 1'b0;
            end
          end else begin
            rec_rem_nxt = rec_rem_r - 1'b1;
            if (rec_rem_r == REC_LEN_W'(1)) begin
              active_nxt = 1'b0;
            end
          end
        end
      end

      REQ_QUEUE: begin
        if (!full && (open_len_r != '0)) begin
          len_we       = 1'b1;
          fill_idx_nxt = idx_inc(fill_idx_r);
          count_nxt    = count_r + 1'b1;
          open_len_nxt = '0;
          if (count_r == '0) begin
            drain_len_nxt = open_len_r;
          end
          active_nxt             = 1'b0;
          head_rem_nxt           = '0;
          rec_rem_nxt            = '0;
          rsp_nxt.queue_accepted = 1'b1;
        end
      end

      REQ_DRAIN_READ: begin
        rsp_nxt.read_hit = rd_hit;
      end

      REQ_WRITE_DONE: begin
        // Release the oldest buffer; the next one's length was kept at close.
        if (count_r != '0) begin
          drain_idx_nxt = idx_inc(drain_idx_r);
          count_nxt     = count_r - 1'b1;
          drain_len_nxt = len_r[idx_inc(drain_idx_r)];
        end
      end

      REQ_CLEAR: begin
        fill_idx_nxt  = '0;
        drain_idx_nxt = '0;
        count_nxt     = '0;
        open_len_nxt  = '0;
        active_nxt    = 1'b0;
        head_rem_nxt  = '0;
        rec_rem_nxt   = '0;
      end

      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_idx_r  <= '0;
      drain_idx_r <= '0;
      count_r     <= '0;
      open_len_r  <= '0;
      drain_len_r <= '0;
      active_r    <= 1'b0;
      head_rem_r  <= '0;
      rec_rem_r   <= '0;
      ovs_ctr_r   <= '0;
      full_ctr_r  <= '0;
    end else if (accept) begin
      fill_idx_r  <= fill_idx_nxt;
      drain_idx_r <= drain_idx_nxt;
      count_r     <= count_nxt;
      open_len_r  <= open_len_nxt;
      drain_len_r <= drain_len_nxt;
      active_r    <= active_nxt;
      head_rem_r  <= head_rem_nxt;
      rec_rem_r   <= rec_rem_nxt;
      ovs_ctr_r   <= ovs_ctr_nxt;
      full_ctr_r  <= full_ctr_nxt;
    end
  end

  // Closed buffer lengths and the per-transaction answer.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_r <= rsp_nxt;
      if (len_we) begin
        len_r[fill_idx_r] <= open_len_r;
      end
    end
  end

  // Byte store access: the write of a data byte or the drain read.
  assign ram_addr  = (accept && ram_we) ? wr_addr : rd_addr;
  assign ram_wdata = in_item.data_byte;

  assign rsp = rsp_r;

  // Ring status after the last transaction.
  assign view.drain_valid       = (count_r != '0);
  assign view.drain_len         = (count_r != '0) ? LEN_FIELD_W'(drain_len_r) : '0;
  assign view.queued_count      = COUNT_FIELD_W'(count_r);
  assign view.open_bytes        = full ? '0 : LEN_FIELD_W'(open_len_r);
  assign view.oversize_refusals = ovs_ctr_r;
  assign view.full_refusals     = full_ctr_r;

endmodule

### rtl/core/rpb_checker.sv
// ----------------------------------------------------------------------------
// Buffer ring port checker
// Watches the core's ports for result timing and consistent ring status.
// ----------------------------------------------------------------------------
module rpb_checker
  import rpb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_strobe,
  input out_item_t out_item
);

  // Each accepted transaction yields a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_strobe)
    else $error("accepted transaction produced no result");

  // No result without a transaction accepted the cycle before.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy))
    else $error("result without an accepted transaction");

  // Drain valid agrees with the queued buffer count.
  a_drain_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.drain_valid == (out_item.queued_count != '0)))
    else $error("drain valid disagrees with queued count");

  // With nothing queued there is no drain length and no read data.
  a_empty_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.drain_valid) |->
      ((out_item.drain_len == '0) && (out_item.read_data == '0)))
    else $error("drain fields nonzero with nothing queued");

  // Only a put start gives a put status.
  a_put_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && ($past(in_item.req_type) != REQ_PUT_START)) |->
      (out_item.put_status == PS_NONE))
    else $error("put status on a transaction that is not a put start");

endmodule

bind record_packing_buffer_ring_core rpb_checker u_rpb_checker (.*);
